FILE: src/packet_sequence_reorder_defines.svh
// ----------------------------------------------------------------------------
// packet_sequence_reorder assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PACKET_SEQUENCE_REORDER_DEFINES_SVH
`define PACKET_SEQUENCE_REORDER_DEFINES_SVH

`ifndef SYNTHESIS
// Checked outside reset.
`define PSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every edge, reset included.
`define PSR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PSR_ASSERT(lbl, prop, msg)
`define PSR_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: src/psr_pkg.sv
// ----------------------------------------------------------------------------
// psr_pkg
// Shared widths, codes and controller/datapath signal groups.
// ----------------------------------------------------------------------------
`default_nettype none

package psr_pkg;

  localparam int SEQ_W      = 32;
  localparam int LEN_W      = 16;
  localparam int HDL_W      = 10;
  localparam int HDL_WIDE_W = 16;  // widest supported stored handle
  localparam int STATUS_W   = 3;

  typedef enum logic [STATUS_W-1:0] {
    ST_RELEASED = 3'd0,
    ST_HELD     = 3'd1,
    ST_STALE    = 3'd2,
    ST_BEYOND   = 3'd3,
    ST_DUP      = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_DRAIN
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic take;   // desc.ready
    logic eval;   // classify the captured item and load its first result
    logic drain;  // emit the next held packet of a release chain
  } psr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_valid;
    logic out_free;     // output register empty or being taken
    logic eval_more;    // captured item is a release and a held packet follows
    logic drain_more;   // another held packet follows the current drain step
  } psr_stat_t;

endpackage

`default_nettype wire

FILE: src/psr_if.sv
// ----------------------------------------------------------------------------
// psr_if
// Valid/ready channels for packet descriptors and resequencer results.
// ----------------------------------------------------------------------------
`default_nettype none

interface psr_desc_if;
  logic                      valid;
  logic                      ready;
  logic [psr_pkg::SEQ_W-1:0] seq_num;
  logic [psr_pkg::LEN_W-1:0] packet_length;
  logic [psr_pkg::HDL_W-1:0] payload_handle;

  modport source (output valid, seq_num, packet_length, payload_handle, input ready);
  modport sink   (input valid, seq_num, packet_length, payload_handle, output ready);
endinterface

interface psr_result_if;
  logic                         valid;
  logic                         ready;
  logic [psr_pkg::STATUS_W-1:0] status;
  logic [psr_pkg::SEQ_W-1:0]    out_seq;
  logic [psr_pkg::LEN_W-1:0]    out_length;
  logic [psr_pkg::HDL_W-1:0]    out_handle;
  logic                         last;

  modport source (output valid, status, out_seq, out_length, out_handle, last,
                  input ready);
  modport sink   (input valid, status, out_seq, out_length, out_handle, last,
                  output ready);
endinterface

`default_nettype wire

FILE: src/psr_ctrl.sv
// ----------------------------------------------------------------------------
// psr_ctrl
// Sequencer: capture an item, classify it, then walk any release chain.
// ----------------------------------------------------------------------------
`default_nettype none

module psr_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire psr_pkg::psr_stat_t  stat,
  output psr_pkg::psr_cmd_t        cmd
);

  psr_pkg::state_t state;
  psr_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      psr_pkg::S_IDLE: begin
        if (stat.in_valid) begin
          state_next = psr_pkg::S_EVAL;
        end
      end
      psr_pkg::S_EVAL: begin
        if (stat.out_free) begin
          state_next = stat.eval_more ? psr_pkg::S_DRAIN : psr_pkg::S_IDLE;
        end
      end
      psr_pkg::S_DRAIN: begin
        if (stat.out_free) begin
          state_next = stat.drain_more ? psr_pkg::S_DRAIN : psr_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = psr_pkg::S_IDLE;
      end
    endcase
  end

  // hold ready low while in reset so no item is taken and then lost
  always_comb begin
    cmd = '0;
    case (state)
      psr_pkg::S_IDLE:  cmd.take  = !rst;
      psr_pkg::S_EVAL:  cmd.eval  = stat.out_free;
      psr_pkg::S_DRAIN: cmd.drain = stat.out_free;
      default:          cmd       = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: src/psr_datapath.sv
// ----------------------------------------------------------------------------
// psr_datapath
// Descriptor capture, window classification, hold store and output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "packet_sequence_reorder_defines.svh"

module psr_datapath #(
  parameter int WINDOW      = 32,
  parameter int HANDLE_BITS = 10
) (
  input  wire logic               clk,
  input  wire logic               rst,
  psr_desc_if.sink                desc,
  psr_result_if.source            result,
  input  wire psr_pkg::psr_cmd_t  cmd,
  output psr_pkg::psr_stat_t      stat
);

  localparam int SW     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int DW     = $clog2(WINDOW + 1);
  localparam int DS     = DW + 1;
  localparam int DESC_W = psr_pkg::LEN_W + HANDLE_BITS;
  localparam logic [DS-1:0] WIN_S = DS'(WINDOW);
  localparam logic [SW-1:0] PMAX  = SW'(WINDOW - 1);
  localparam logic [psr_pkg::HDL_WIDE_W-1:0] HMASK =
    psr_pkg::HDL_WIDE_W'((32'd1 << HANDLE_BITS) - 32'd1);

  // captured item
  logic [psr_pkg::SEQ_W-1:0] seq_r;
  logic [psr_pkg::LEN_W-1:0] len_r;
  logic [psr_pkg::HDL_W-1:0] hdl_r;

  // window state; ptr tracks last_delivered modulo WINDOW
  logic [psr_pkg::SEQ_W-1:0] last_delivered;
  logic [SW-1:0]             ptr;
  logic [WINDOW-1:0]         valid_bits;
  logic [DW-1:0]             cnt;
  logic [DESC_W-1:0]         mem [WINDOW];
  logic [DESC_W-1:0]         rd_data;

  // output register
  logic                      out_valid;
  psr_pkg::status_t          out_status;
  logic [psr_pkg::SEQ_W-1:0] out_seq;
  logic [psr_pkg::LEN_W-1:0] out_length;
  logic [psr_pkg::HDL_W-1:0] out_handle;
  logic                      out_last;

  logic [psr_pkg::HDL_WIDE_W-1:0] hdl_in16;
  logic [psr_pkg::HDL_WIDE_W-1:0] hdl_in_keep;
  logic [psr_pkg::HDL_WIDE_W-1:0] hdl_r16;
  logic [psr_pkg::HDL_WIDE_W-1:0] rd_hdl16;
  logic [psr_pkg::SEQ_W-1:0]      diff;
  logic [psr_pkg::SEQ_W-1:0]      last_inc;
  logic [DS-1:0]                  slot_sum;
  logic [SW-1:0]                  held_slot;
  logic [SW-1:0]                  ptr_inc;
  logic [SW-1:0]                  ptr_inc2;
  logic                           stale;
  logic                           beyond;
  logic                           rel;
  logic                           dup;
  logic                           hold_new;
  logic                           eval_more;
  logic                           drain_more;
  psr_pkg::status_t               eval_status;

  assign hdl_in16    = psr_pkg::HDL_WIDE_W'(desc.payload_handle);
  assign hdl_in_keep = hdl_in16 & HMASK;
  assign hdl_r16     = psr_pkg::HDL_WIDE_W'(hdl_r);
  assign rd_hdl16    = psr_pkg::HDL_WIDE_W'(rd_data[HANDLE_BITS-1:0]);

  // classification of the captured item
  assign stale     = (seq_r <= last_delivered);
  assign diff      = seq_r - last_delivered;
  assign beyond    = !stale && (diff > psr_pkg::SEQ_W'(WINDOW));
  assign rel       = !stale && (diff == psr_pkg::SEQ_W'(1));
  assign slot_sum  = DS'(ptr) + diff[DS-1:0];
  assign held_slot = (slot_sum >= WIN_S) ? SW'(slot_sum - WIN_S) : SW'(slot_sum);
  assign dup       = valid_bits[held_slot];
  assign hold_new  = !stale && !beyond && !rel && !dup;

  assign ptr_inc  = (ptr == PMAX) ? '0 : ptr + 1'b1;
  assign ptr_inc2 = (ptr_inc == PMAX) ? '0 : ptr_inc + 1'b1;
  assign last_inc = last_delivered + 1'b1;

  // on a release the captured item sits in slot ptr_inc, the next one in ptr_inc2
  assign eval_more  = rel && (seq_r != '1) && valid_bits[ptr_inc2];
  assign drain_more = ((DS'(cnt) + DS'(1)) < WIN_S) && (last_inc != '1) &&
                      valid_bits[ptr_inc2];

  always_comb begin
    if (stale) begin
      eval_status = psr_pkg::ST_STALE;
    end else if (beyond) begin
      eval_status = psr_pkg::ST_BEYOND;
    end else if (rel) begin
      eval_status = psr_pkg::ST_RELEASED;
    end else if (dup) begin
      eval_status = psr_pkg::ST_DUP;
    end else begin
      eval_status = psr_pkg::ST_HELD;
    end
  end

  assign stat.in_valid   = desc.valid;
  assign stat.out_free   = !out_valid || result.ready;
  assign stat.eval_more  = eval_more;
  assign stat.drain_more = drain_more;

  assign desc.ready        = cmd.take;
  assign result.valid      = out_valid;
  assign result.status     = out_status;
  assign result.out_seq    = out_seq;
  assign result.out_length = out_length;
  assign result.out_handle = out_handle;
  assign result.last       = out_last;

  // capture
  always_ff @(posedge clk) begin
    if (cmd.take && desc.valid) begin
      seq_r <= desc.seq_num;
      len_r <= desc.packet_length;
      hdl_r <= hdl_in_keep[psr_pkg::HDL_W-1:0];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      last_delivered <= '0;
      ptr            <= '0;
      valid_bits     <= '0;
      cnt            <= '0;
    end else begin
      if (cmd.eval || cmd.drain) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.eval) begin
        if (hold_new) begin
          valid_bits[held_slot] <= 1'b1;
        end
        if (rel) begin
          last_delivered <= seq_r;
          ptr            <= ptr_inc;
          cnt            <= DW'(1);
        end
      end
      if (cmd.drain) begin
        valid_bits[ptr_inc] <= 1'b0;
        last_delivered      <= last_inc;
        ptr                 <= ptr_inc;
        cnt                 <= cnt + 1'b1;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      out_status <= eval_status;
      out_seq    <= seq_r;
      out_length <= len_r;
      out_handle <= hdl_r;
      out_last   <= !eval_more;
    end else if (cmd.drain) begin
      out_status <= psr_pkg::ST_RELEASED;
      out_seq    <= last_inc;
      out_length <= rd_data[DESC_W-1 -: psr_pkg::LEN_W];
      out_handle <= rd_hdl16[psr_pkg::HDL_W-1:0];
      out_last   <= !drain_more;
    end
  end

  // hold store
  always_ff @(posedge clk) begin
    if (cmd.eval && hold_new) begin
      mem[held_slot] <= {len_r, hdl_r16[HANDLE_BITS-1:0]};
    end
  end

  // prefetch the next packet of a release chain
  always_ff @(posedge clk) begin
    if ((cmd.eval && eval_more) || (cmd.drain && drain_more)) begin
      rd_data <= mem[ptr_inc2];
    end
  end

  `PSR_ASSERT(a_drain_held, cmd.drain |-> valid_bits[ptr_inc], "drain step on an empty slot")
  `PSR_ASSERT(a_hold_slot, (cmd.eval && hold_new) |-> (held_slot != ptr_inc), "early packet stored in the next expected slot")
  `PSR_ASSERT(a_last_mono, !$past(rst) |-> (last_delivered >= $past(last_delivered)), "last delivered number went backwards")
  `PSR_ASSERT(a_no_overwrite, (cmd.eval || cmd.drain) |-> (!out_valid || result.ready), "result loaded over a pending result")
  `PSR_ASSERT_ALWAYS(a_out_reset, rst |=> !out_valid, "result pending right after reset")

endmodule

`default_nettype wire

FILE: src/packet_sequence_reorder.sv
// ----------------------------------------------------------------------------
// packet_sequence_reorder
// Resequencer that releases numbered packet descriptors in order.
// ----------------------------------------------------------------------------
// Usage:
//   desc   : packet descriptors in (seq_num, packet_length, payload_handle).
//   result : one or more items per descriptor (status, out_seq, out_length,
//            out_handle, last); last marks the final item of a descriptor.
//   The next expected packet is released together with every held packet
//   that now follows on consecutively. Early packets up to WINDOW ahead are
//   held in a window store; stale, far-ahead and duplicate packets are
//   flagged and dropped.
// Sequence:
//   A descriptor is taken while the sequencer is idle and is classified once
//   the output register is free, which loads its first item into the output
//   register. No new descriptor is taken until the last item of the current
//   one is loaded. Each extra released packet of a chain is loaded as its own
//   item, read through the single read port of the window store.
// Reset:
//   rst clears the last delivered number to zero and all window valid bits
//   at once; no clearing pass is needed. desc.ready stays low during reset.
// Backpressure:
//   A stalled receiver holds the pending item in the output register and
//   freezes classification and draining until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module packet_sequence_reorder #(
  parameter int WINDOW      = 32,
  parameter int HANDLE_BITS = 10
) (
  input  wire logic    clk,
  input  wire logic    rst,
  psr_desc_if.sink     desc,
  psr_result_if.source result
);

  psr_pkg::psr_cmd_t  cmd;
  psr_pkg::psr_stat_t stat;

  // sequencer: idle -> classify -> drain chain
  psr_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  // window store, compare logic and output register
  psr_datapath #(
    .WINDOW      (WINDOW),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .desc   (desc),
    .result (result),
    .cmd    (cmd),
    .stat   (stat)
  );

endmodule

`default_nettype wire

FILE: verif/packet_sequence_reorder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// packet_sequence_reorder_tb
// Self-checking bench for the packet resequencer. A short table of directed
// descriptors covers the stale, held, duplicate, far-ahead and release cases.
// Random descriptor blocks follow: mostly shuffled runs of upcoming numbers,
// plus noise and broken runs. Every result item is checked against the
// expected item from its directed row or from an in-bench window model.
// ----------------------------------------------------------------------------
module packet_sequence_reorder_tb;

  localparam int WIN            = 32;
  localparam int RAND_ITEMS     = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 40;
  localparam int LONG_HOLD      = 150;

  // One descriptor as the sender sees it.
  typedef struct packed {
    logic [psr_pkg::SEQ_W-1:0] seq;
    logic [psr_pkg::LEN_W-1:0] len;
    logic [psr_pkg::HDL_W-1:0] hdl;
  } pkt_t;

  // One result item as the receiver sees it.
  typedef struct packed {
    logic [psr_pkg::STATUS_W-1:0] status;
    logic [psr_pkg::SEQ_W-1:0]    seq;
    logic [psr_pkg::LEN_W-1:0]    len;
    logic [psr_pkg::HDL_W-1:0]    hdl;
    logic                         last;
  } result_t;

  // Directed row: when typed is set, the single result item is fixed by the
  // row itself (input echoed, last set); otherwise the window model decides.
  typedef struct packed {
    logic [psr_pkg::SEQ_W-1:0]    seq;
    logic [psr_pkg::LEN_W-1:0]    len;
    logic [psr_pkg::HDL_W-1:0]    hdl;
    logic                         typed;
    logic [psr_pkg::STATUS_W-1:0] status;
  } dir_row_t;

  localparam int DIR_ROWS = 18;

  // Walk from reset: stale zero, far packets, a held/duplicate pair, two short
  // chains, stale repeats, single releases and bit patterns on every field.
  dir_row_t directed [DIR_ROWS] = '{
    '{32'd0,          16'h0000, 10'h000, 1'b1, psr_pkg::ST_STALE},
    '{32'hFFFF_FFFF,  16'hFFFF, 10'h3FF, 1'b1, psr_pkg::ST_BEYOND},
    '{32'd33,         16'd1234, 10'd5,   1'b1, psr_pkg::ST_BEYOND},
    '{32'd32,         16'hFFFF, 10'h3FF, 1'b1, psr_pkg::ST_HELD},
    '{32'd32,         16'd7,    10'd1,   1'b1, psr_pkg::ST_DUP},
    '{32'd3,          16'd100,  10'd200, 1'b1, psr_pkg::ST_HELD},
    '{32'd2,          16'h0000, 10'h3FF, 1'b1, psr_pkg::ST_HELD},
    '{32'd5,          16'd1500, 10'd77,  1'b1, psr_pkg::ST_HELD},
    '{32'd1,          16'd64,   10'd9,   1'b0, psr_pkg::ST_RELEASED},
    '{32'd2,          16'd11,   10'd12,  1'b1, psr_pkg::ST_STALE},
    '{32'd3,          16'd13,   10'd14,  1'b1, psr_pkg::ST_STALE},
    '{32'd4,          16'd40,   10'd400, 1'b0, psr_pkg::ST_RELEASED},
    '{32'd6,          16'd60,   10'd600, 1'b1, psr_pkg::ST_RELEASED},
    '{32'd39,         16'd390,  10'd39,  1'b1, psr_pkg::ST_BEYOND},
    '{32'd38,         16'd380,  10'd38,  1'b1, psr_pkg::ST_HELD},
    '{32'd7,          16'hFFFF, 10'h000, 1'b1, psr_pkg::ST_RELEASED},
    '{32'h8000_0000,  16'h5555, 10'h2AA, 1'b1, psr_pkg::ST_BEYOND},
    '{32'h7FFF_FFFF,  16'hAAAA, 10'h155, 1'b1, psr_pkg::ST_BEYOND}
  };

  logic clk;
  logic rst = 1'b1;

  psr_desc_if   desc_ch ();
  psr_result_if res_ch ();

  packet_sequence_reorder #(
    .WINDOW      (WIN),
    .HANDLE_BITS (psr_pkg::HDL_W)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .desc   (desc_ch),
    .result (res_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Window model: last released number plus one slot per (seq mod WIN).
  // --------------------------------------------------------------------------
  logic [psr_pkg::SEQ_W-1:0] last_released = '0;
  logic                      window_busy [WIN];
  logic [psr_pkg::LEN_W-1:0] window_len  [WIN];
  logic [psr_pkg::HDL_W-1:0] window_hdl  [WIN];

  result_t step_results [$];      // items caused by the descriptor just taken
  result_t awaited_results [$];   // items still owed by the block, oldest first

  int  errors = 0;
  int  items_sent = 0;
  bit  steady = 1'b0;             // no random idling on either side while set
  int  rx_hold = 0;               // one long receiver stall, in cycles

  initial begin
    for (int i = 0; i < WIN; i++) window_busy[i] = 1'b0;
  end

  // Classify one descriptor and update the window, filling step_results.
  function automatic void resequence(input pkt_t p);
    logic [psr_pkg::SEQ_W-1:0] span;
    logic [psr_pkg::SEQ_W-1:0] cur;
    logic [psr_pkg::SEQ_W-1:0] nxt;
    int                        idx;
    int                        n;
    bit                        going;
    result_t                   tail;
    step_results.delete();
    if (p.seq <= last_released) begin
      step_results.push_back(result_t'{psr_pkg::ST_STALE, p.seq, p.len, p.hdl, 1'b1});
      return;
    end
    span = p.seq - last_released;
    if (span > WIN) begin
      step_results.push_back(result_t'{psr_pkg::ST_BEYOND, p.seq, p.len, p.hdl, 1'b1});
      return;
    end
    if (span >= 2) begin
      idx = p.seq % WIN;
      if (window_busy[idx]) begin
        // keep the held copy, flag the second one
        step_results.push_back(result_t'{psr_pkg::ST_DUP, p.seq, p.len, p.hdl, 1'b1});
      end else begin
        window_busy[idx] = 1'b1;
        window_len[idx]  = p.len;
        window_hdl[idx]  = p.hdl;
        step_results.push_back(result_t'{psr_pkg::ST_HELD, p.seq, p.len, p.hdl, 1'b1});
      end
      return;
    end
    // Next expected number: release it, then drain the run of held packets.
    step_results.push_back(result_t'{psr_pkg::ST_RELEASED, p.seq, p.len, p.hdl, 1'b0});
    cur   = p.seq;
    n     = 1;
    going = 1'b1;
    while (going && n < WIN && cur != '1) begin
      nxt = cur + 1'b1;
      idx = nxt % WIN;
      if (!window_busy[idx]) begin
        going = 1'b0;
      end else begin
        window_busy[idx] = 1'b0;
        step_results.push_back(result_t'{psr_pkg::ST_RELEASED, nxt, window_len[idx],
                                         window_hdl[idx], 1'b0});
        n++;
        cur = nxt;
      end
    end
    tail = step_results.pop_back();
    tail.last = 1'b1;
    step_results.push_back(tail);
    last_released = cur;
  endfunction

  // Favor the extremes now and then; otherwise the full range.
  function automatic logic [psr_pkg::LEN_W-1:0] pick_len();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return psr_pkg::LEN_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [psr_pkg::HDL_W-1:0] pick_hdl();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return psr_pkg::HDL_W'($urandom_range(0, 1023));
    endcase
  endfunction

  task automatic note_error(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  // --------------------------------------------------------------------------
  // Sender: offer one descriptor, hold it until taken, then predict. Valid
  // stays high on return so back-to-back items need no extra assignment.
  // --------------------------------------------------------------------------
  task automatic send_desc(input pkt_t p, input logic typed,
                           input logic [psr_pkg::STATUS_W-1:0] status);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      desc_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    desc_ch.valid          <= 1'b1;
    desc_ch.seq_num        <= p.seq;
    desc_ch.packet_length  <= p.len;
    desc_ch.payload_handle <= p.hdl;
    do @(posedge clk); while (!desc_ch.ready);
    items_sent++;
    resequence(p);
    if (typed) begin
      awaited_results.push_back(result_t'{status, p.seq, p.len, p.hdl, 1'b1});
    end else begin
      foreach (step_results[i]) awaited_results.push_back(step_results[i]);
    end
  endtask

  // Drop valid and hold until the block owes nothing; the clock is always awaited
  // before the check, so valid is never dropped and raised in the same step.
  task automatic drain_pause();
    desc_ch.valid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Main stimulus: reset, directed table, random phases, then the end check.
  // --------------------------------------------------------------------------
  initial begin
    pkt_t                      p;
    logic [psr_pkg::SEQ_W-1:0] run [$];
    logic [psr_pkg::SEQ_W-1:0] held_seqs [$];
    logic [psr_pkg::SEQ_W-1:0] tmp;
    logic [psr_pkg::SEQ_W-1:0] s;
    int                        phase;
    int                        pick;
    int                        k;
    int                        j;
    int                        bursts;

    desc_ch.valid          <= 1'b0;
    desc_ch.seq_num        <= '0;
    desc_ch.packet_length  <= '0;
    desc_ch.payload_handle <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part: run the table with idling on.
    for (int r = 0; r < DIR_ROWS; r++) begin
      p = pkt_t'{directed[r].seq, directed[r].len, directed[r].hdl};
      send_desc(p, directed[r].typed, directed[r].status);
    end
    drain_pause();

    // Random part. Most phases send a shuffled run of the next numbers so
    // that early packets get held and the final gap fill drains a chain.
    phase = 0;
    while (items_sent < DIR_ROWS + RAND_ITEMS) begin
      phase++;
      steady = ($urandom_range(0, 3) == 0);
      pick   = $urandom_range(0, 9);

      // Stall the receiver for a long stretch while a full window streams
      // in, so the block backs up and drops ready on its input.
      if (phase == 4) begin
        rx_hold = LONG_HOLD;
        steady  = 1'b1;
        pick    = 9;
      end

      if (pick <= 6 || pick == 9) begin
        k = (pick == 9) ? WIN : $urandom_range(1, 8);
        run.delete();
        for (int i = 1; i <= k; i++) run.push_back(last_released + i);
        for (int i = k - 1; i > 0; i--) begin
          j      = $urandom_range(0, i);
          tmp    = run[i];
          run[i] = run[j];
          run[j] = tmp;
        end
        // Broken run: drop one number so a gap stays open.
        if (pick == 6 && k > 1) run.delete($urandom_range(0, k - 1));
        // Now and then repeat a number of the run.
        if ($urandom_range(0, 4) == 0 && run.size() != 0)
          run.push_back(run[$urandom_range(0, run.size() - 1)]);
        foreach (run[i]) begin
          p = pkt_t'{run[i], pick_len(), pick_hdl()};
          send_desc(p, 1'b0, psr_pkg::ST_RELEASED);
        end
      end else begin
        // Noise: stale, far, random, early, duplicate of a held number, all ones.
        bursts = $urandom_range(3, 6);
        for (int b = 0; b < bursts; b++) begin
          case ($urandom_range(0, 5))
            0: s = $urandom_range(0, last_released);
            1: s = last_released + WIN + 1 + $urandom_range(0, 1000);
            2: s = $urandom;
            3: s = last_released + $urandom_range(2, WIN);
            4: begin
              held_seqs.delete();
              for (int d = 2; d <= WIN; d++) begin
                tmp = last_released + d;
                if (window_busy[tmp % WIN]) held_seqs.push_back(tmp);
              end
              if (held_seqs.size() != 0)
                s = held_seqs[$urandom_range(0, held_seqs.size() - 1)];
              else
                s = last_released + $urandom_range(2, WIN);
            end
            default: s = '1;
          endcase
          p = pkt_t'{s, pick_len(), pick_hdl()};
          send_desc(p, 1'b0, psr_pkg::ST_RELEASED);
        end
      end

      // Let the block run dry before the next phase at times.
      if (phase == 8 || $urandom_range(0, 7) == 0) drain_pause();
    end

    // Wind down: stop offering, collect everything owed, watch for extras.
    steady = 1'b0;
    drain_pause();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: stall at random, take one item, compare with the oldest owed.
  // --------------------------------------------------------------------------
  initial begin
    int      stall;
    result_t got;
    result_t want;
    res_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (rx_hold != 0) begin
        stall   = rx_hold;
        rx_hold = 0;
      end else begin
        stall = steady ? 0 : $urandom_range(0, 3);
      end
      if (stall != 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      got = result_t'{res_ch.status, res_ch.out_seq, res_ch.out_length,
                      res_ch.out_handle, res_ch.last};
      if (awaited_results.size() == 0) begin
        note_error($sformatf("unexpected item: status %0d seq %0d len %0d hdl %0d last %0b",
                             got.status, got.seq, got.len, got.hdl, got.last));
      end else begin
        want = awaited_results.pop_front();
        if (got !== want)
          note_error($sformatf({"mismatch: expected status %0d seq %0d len %0d hdl %0d ",
                                "last %0b, got status %0d seq %0d len %0d hdl %0d last %0b"},
                               want.status, want.seq, want.len, want.hdl, want.last,
                               got.status, got.seq, got.len, got.hdl, got.last));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run if neither channel moves an item for too long.
  // --------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((desc_ch.valid && desc_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule
